FILE: rtl/efps_pkg.sv
`default_nettype none
package efps_pkg;

   localparam int MAX_TASKS_DEFAULT = 16;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [1:0] CSR_TASK_COUNT       = 2'd0;
   localparam logic [1:0] CSR_BATTERY_CAPACITY = 2'd1;
   localparam logic [1:0] CSR_BATTERY_FLOOR    = 2'd2;

   localparam logic [4:0]  TASK_COUNT_RESET = 5'd10;
   localparam logic [15:0] CAPACITY_RESET   = 16'd90;
   localparam logic [15:0] FLOOR_RESET      = 16'd0;

   typedef struct packed {
      logic        command;
      logic [3:0]  task_index;
      logic [15:0] task_period;
      logic [15:0] task_work;
      logic [15:0] task_energy;
      logic [15:0] harvest_power;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic        deadline_missed;
      logic [3:0]  missed_task;
      logic        task_ran;
      logic [3:0]  ran_task;
      logic [15:0] battery_level;
      logic        schedule_failed;
   } rsp_type;

   // one task table row
   typedef struct packed {
      logic [15:0] period;
      logic [15:0] work;
      logic [15:0] energy;
      logic [15:0] countdown;
      logic [15:0] left;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [15:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

FILE: rtl/efps_ram.sv
`default_nettype none
module efps_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic                                         rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: rtl/efps_divider.sv
`default_nettype none
module efps_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire efps_pkg::div_req_type div_req,
   output      efps_pkg::div_rsp_type div_rsp
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [16:0] shifted;

   // restoring division, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      shifted = {rem_ff, quo_ff[15]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         rem_in  = 16'd0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = 16'(shifted - {1'b0, dsr_ff});
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = shifted[15:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule
`default_nettype wire

FILE: rtl/energy_aware_fixed_priority_scheduler_core.sv
// Load request: the row is written once the divider has computed its slot energy.
// Tick request: one row per cycle through the single-port-read task memory for the
// in-use rows (a deadline miss ends the walk), then the battery decision in S_DECIDE.
// A frozen tick (after a deadline miss) goes straight to S_DONE without a walk. One request at a time.
// Synchronous reset clears battery and failure flag and loads the CSR defaults; the task table is
// undefined until each row is loaded.
`default_nettype none
module energy_aware_fixed_priority_scheduler_core #(
   parameter int MAX_TASKS = efps_pkg::MAX_TASKS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire efps_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      efps_pkg::rsp_type rsp_data,
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);
   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int ENT_W = $bits(efps_pkg::entry_type);

   typedef enum logic [2:0] {S_IDLE, S_DIV, S_WALK, S_DECIDE, S_DONE} state_type;

   state_type            state_ff, state_in;
   logic [4:0]           task_count_ff, task_count_in;
   logic [15:0]          capacity_ff, capacity_in;
   logic [15:0]          floor_ff, floor_in;
   logic [15:0]          battery_ff, battery_in;
   logic                 failed_ff, failed_in;
   logic                 cmd_ff, cmd_in;
   logic [3:0]           ld_idx_ff, ld_idx_in;
   logic [15:0]          ld_period_ff, ld_period_in;
   logic [15:0]          ld_work_ff, ld_work_in;
   logic [15:0]          harvest_ff, harvest_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]     eval_idx_ff, eval_idx_in;
   logic                 miss_ff, miss_in;
   logic [IDX_W-1:0]     miss_idx_ff, miss_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     sel_idx_ff, sel_idx_in;
   efps_pkg::entry_type  sel_ent_ff, sel_ent_in;
   efps_pkg::rsp_type    res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   efps_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]     n_use;
   logic                 wr_en, rd_en;
   logic [IDX_W-1:0]     wr_addr, rd_addr;
   efps_pkg::entry_type  wr_ent, rd_ent, upd_ent;
   logic [ENT_W-1:0]     rd_raw;
   logic                 expired, eval_go, eval_miss, eval_last;
   logic [16:0]          have_sum, need_sum;
   logic [15:0]          drain;
   efps_pkg::div_req_type div_req;
   efps_pkg::div_rsp_type div_rsp;
   logic                 req_acc, out_free;

   efps_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   efps_ram #(.WIDTH(ENT_W), .DEPTH(MAX_TASKS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_ent    = efps_pkg::entry_type'(rd_raw);
   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign div_req.start    = req_acc && (req_data.command == efps_pkg::CMD_LOAD);
   assign div_req.dividend = req_data.task_energy;
   assign div_req.divisor  = req_data.task_work;

   always_comb begin
      if (32'(task_count_ff) > MAX_TASKS) begin
         n_use = CNT_W'(MAX_TASKS);
      end else begin
         n_use = CNT_W'(task_count_ff);
      end
   end

   // walk evaluation of the row read last cycle
   always_comb begin
      expired   = (rd_ent.countdown <= 16'd1);
      eval_go   = pipe_vld_ff && (state_ff == S_WALK);
      eval_miss = eval_go && expired && (rd_ent.left != 16'd0);
      eval_last = (CNT_W'(eval_idx_ff) + CNT_W'(1)) == n_use;
      upd_ent   = rd_ent;
      if (expired) begin
         upd_ent.left      = rd_ent.work;
         upd_ent.countdown = rd_ent.period;
      end else begin
         upd_ent.countdown = rd_ent.countdown - 16'd1;
      end
   end

   assign have_sum = {1'b0, battery_ff} + {1'b0, harvest_ff};
   assign need_sum = {1'b0, floor_ff} + {1'b0, sel_ent_ff.energy};
   assign drain    = sel_ent_ff.energy - harvest_ff;
   assign rd_en    = (state_ff == S_WALK) && (issue_ff < n_use);
   assign rd_addr  = issue_ff[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      task_count_in = task_count_ff;
      capacity_in   = capacity_ff;
      floor_in      = floor_ff;
      battery_in    = battery_ff;
      failed_in     = failed_ff;
      cmd_in        = cmd_ff;
      ld_idx_in     = ld_idx_ff;
      ld_period_in  = ld_period_ff;
      ld_work_in    = ld_work_ff;
      harvest_in    = harvest_ff;
      issue_in      = issue_ff;
      pipe_vld_in   = rd_en;
      eval_idx_in   = rd_addr;
      miss_in       = miss_ff;
      miss_idx_in   = miss_idx_ff;
      found_in      = found_ff;
      sel_idx_in    = sel_idx_ff;
      sel_ent_in    = sel_ent_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = eval_idx_ff;
      wr_ent        = upd_ent;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            efps_pkg::CSR_TASK_COUNT:       task_count_in = csr_wdata[4:0];
            efps_pkg::CSR_BATTERY_CAPACITY: capacity_in   = csr_wdata;
            efps_pkg::CSR_BATTERY_FLOOR:    floor_in      = csr_wdata;
            default: ;
         endcase
      end

      if (rd_en) begin
         issue_in = issue_ff + CNT_W'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               cmd_in       = req_data.command;
               ld_idx_in    = req_data.task_index;
               ld_period_in = req_data.task_period;
               ld_work_in   = req_data.task_work;
               harvest_in   = req_data.harvest_power;
               issue_in     = '0;
               miss_in      = 1'b0;
               miss_idx_in  = '0;
               found_in     = 1'b0;
               sel_idx_in   = '0;
               res_in       = '0;
               res_in.item_kind = req_data.command;
               if (req_data.command == efps_pkg::CMD_LOAD) begin
                  state_in = S_DIV;
               end else if (failed_ff) begin
                  res_in.battery_level   = battery_ff;
                  res_in.schedule_failed = 1'b1;
                  state_in = S_DONE;
               end else if (n_use == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               wr_en   = (32'(ld_idx_ff) < MAX_TASKS);
               wr_addr = IDX_W'(ld_idx_ff);
               wr_ent.period    = ld_period_ff;
               wr_ent.work      = ld_work_ff;
               wr_ent.energy    = (ld_work_ff == 16'd0) ? 16'hFFFF : div_rsp.quotient;
               wr_ent.countdown = ld_period_ff;
               wr_ent.left      = ld_work_ff;
               res_in.battery_level   = battery_ff;
               res_in.schedule_failed = failed_ff;
               state_in = S_DONE;
            end
         end
         S_WALK: begin
            if (eval_go) begin
               if (eval_miss) begin
                  miss_in     = 1'b1;
                  miss_idx_in = eval_idx_ff;
                  state_in    = S_DECIDE;
               end else begin
                  wr_en = 1'b1;
                  // later rows override: highest index with work wins
                  if (upd_ent.left != 16'd0) begin
                     found_in   = 1'b1;
                     sel_idx_in = eval_idx_ff;
                     sel_ent_in = upd_ent;
                  end
                  if (eval_last) begin
                     state_in = S_DECIDE;
                  end
               end
            end
         end
         S_DECIDE: begin
            if (miss_ff) begin
               failed_in = 1'b1;
               res_in.deadline_missed = 1'b1;
               res_in.missed_task     = 4'(miss_idx_ff);
               res_in.battery_level   = battery_ff;
               res_in.schedule_failed = 1'b1;
            end else begin
               if (found_ff && (have_sum >= need_sum)) begin
                  wr_en          = 1'b1;
                  wr_addr        = sel_idx_ff;
                  wr_ent         = sel_ent_ff;
                  wr_ent.left    = sel_ent_ff.left - 16'd1;
                  res_in.task_ran = 1'b1;
                  res_in.ran_task = 4'(sel_idx_ff);
                  if (sel_ent_ff.energy >= harvest_ff) begin
                     battery_in = (drain <= battery_ff) ? battery_ff - drain : 16'd0;
                  end
               end else if (have_sum >= {1'b0, capacity_ff}) begin
                  battery_in = capacity_ff;
               end else begin
                  battery_in = have_sum[15:0];
               end
               res_in.battery_level   = battery_in;
               res_in.schedule_failed = failed_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         task_count_ff <= efps_pkg::TASK_COUNT_RESET;
         capacity_ff   <= efps_pkg::CAPACITY_RESET;
         floor_ff      <= efps_pkg::FLOOR_RESET;
         battery_ff    <= 16'd0;
         failed_ff     <= 1'b0;
         pipe_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         task_count_ff <= task_count_in;
         capacity_ff   <= capacity_in;
         floor_ff      <= floor_in;
         battery_ff    <= battery_in;
         failed_ff     <= failed_in;
         pipe_vld_ff   <= pipe_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      ld_idx_ff    <= ld_idx_in;
      ld_period_ff <= ld_period_in;
      ld_work_ff   <= ld_work_in;
      harvest_ff   <= harvest_in;
      issue_ff     <= issue_in;
      eval_idx_ff  <= eval_idx_in;
      miss_ff      <= miss_in;
      miss_idx_ff  <= miss_idx_in;
      found_ff     <= found_in;
      sel_idx_ff   <= sel_idx_in;
      sel_ent_ff   <= sel_ent_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("table write and read hit the same row");

   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      failed_ff |=> failed_ff)
      else $error("failure flag cleared without reset");

   a_div_done_in_load: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider finished outside a load");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished request not presented");

   a_kind_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (res_ff.item_kind == cmd_ff))
      else $error("response kind differs from request");
endmodule
`default_nettype wire
